/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk edge outside reset.
`define VLPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check that a trigger is followed in the next cycle by a property.
`define VLPF_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error(msg);

`endif

/* design/vlpf_pkg.sv */
// ----------------------------------------------------------------------------
// vlpf_pkg
// Sizes, opcodes, status codes and ring index helper for the packet FIFO.
// ----------------------------------------------------------------------------
package vlpf_pkg;

  localparam int POOL_DEPTH     = 4096;
  localparam int ADDR_W         = $clog2(POOL_DEPTH);
  localparam int LEVEL_W        = 13;
  localparam int LEN_W          = 7;
  localparam int HDR_BYTES      = 8;
  localparam int MAX_ELEM_BYTES = 64;
  localparam int POOL_MIN       = 16;

  // Transaction opcodes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_PULL  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_TOO_BIG = 2'd2;
  localparam logic [1:0] STAT_EMPTY   = 2'd3;

  // Advance a ring index by a small step, wrapping at the live pool size.
  // The index is always below the pool and the step below the minimum pool,
  // so one compare and subtract is enough.
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] idx,
                                                 input logic [3:0] step,
                                                 input logic [LEVEL_W-1:0] pool);
    logic [LEVEL_W-1:0] sum;
    sum = LEVEL_W'(idx) + LEVEL_W'(step);
    if (sum >= pool) begin
      sum = sum - pool;
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

/* design/vlpf_ring_ram.sv */
// ----------------------------------------------------------------------------
// vlpf_ring_ram
// Byte ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vlpf_ring_ram import vlpf_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [POOL_DEPTH];

  // Write one byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one byte into the registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/variable_length_packet_fifo_top.sv */
// ----------------------------------------------------------------------------
// variable_length_packet_fifo_top
// Length-prefixed packet FIFO on a byte ring held in a single-port-pair RAM.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+--------------------
//  command  | opcode, push_byte, elem_len               | start & !busy
//  config   | cfg_data                                  | cfg_we
//  result   | status, data_byte, last, elem_length,     | result_valid strobe
//           | fill_level, elem_count                    |
//
//  Push bytes are taken in S_IDLE, but the first byte of an accepted element
//  also passes through S_PUSH, as its header byte and payload byte share the
//  RAM write port. A pull reads the header from S_IDLE, decodes its length in
//  S_PULL_HDR, then sends one payload byte per cycle from S_PULL_DATA through
//  the RAM read port. Clear and an empty pull finish in S_IDLE. Results are
//  registered. Reset (synchronous) empties the queue and sets the pool to 4096
//  bytes; the ring RAM needs no clearing. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module variable_length_packet_fifo_top import vlpf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [7:0]         push_byte,
  input  logic [LEN_W-1:0]   elem_len,
  input  logic               cfg_we,
  input  logic [LEVEL_W-1:0] cfg_data,
  output logic               result_valid,
  output logic [1:0]         status,
  output logic [7:0]         data_byte,
  output logic               last,
  output logic [LEN_W-1:0]   elem_length,
  output logic [LEVEL_W-1:0] fill_level,
  output logic [LEVEL_W-1:0] elem_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_PULL_HDR,
    S_PULL_DATA
  } state_t;

  state_t state, state_next;

  logic [LEVEL_W-1:0] pool, pool_next;
  logic [ADDR_W-1:0]  write_index, write_index_next;
  logic [ADDR_W-1:0]  read_index, read_index_next;
  logic [ADDR_W-1:0]  cursor, cursor_next;
  logic [ADDR_W-1:0]  rd_idx, rd_idx_next;
  logic [LEVEL_W-1:0] level, level_next;
  logic [LEVEL_W-1:0] count, count_next;
  logic [LEN_W-1:0]   remaining, remaining_next;
  logic [LEN_W-1:0]   push_len, push_len_next;
  logic [1:0]         verdict, verdict_next;
  logic [7:0]         pend_byte, pend_byte_next;
  logic [LEN_W-1:0]   pull_len, pull_len_next;
  logic [LEN_W-1:0]   pull_left, pull_left_next;

  logic               res_valid_next;
  logic [1:0]         res_status_next;
  logic [7:0]         res_data_next;
  logic               res_last_next;
  logic [LEN_W-1:0]   res_len_next;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [7:0]         mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [7:0]         mem_rdata;

  logic [LEN_W-1:0]   len_in;
  logic [LEVEL_W-1:0] need_in;
  logic [1:0]         first_verdict;
  logic [LEN_W-1:0]   hdr_len;
  logic [LEVEL_W-1:0] hdr_need;
  logic [LEVEL_W-1:0] pool_cfg;

  logic               byte_go;
  logic               byte_store;
  logic [7:0]         byte_data;
  logic [LEN_W-1:0]   step_rem;
  logic [1:0]         step_verdict;
  logic [LEN_W-1:0]   step_len;
  logic [ADDR_W-1:0]  cursor_adv;

  vlpf_ring_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy = (state != S_IDLE);

  // Check the declared length of an element's first byte
  always_comb begin
    len_in  = (elem_len == '0) ? LEN_W'(1) : elem_len;
    need_in = LEVEL_W'(HDR_BYTES) + LEVEL_W'(len_in);
    if ((len_in > LEN_W'(MAX_ELEM_BYTES)) || (need_in > pool)) begin
      first_verdict = STAT_TOO_BIG;
    end else if ((level + need_in) > pool) begin
      first_verdict = STAT_FULL;
    end else begin
      first_verdict = STAT_OK;
    end
  end

  // Decode the length held in a header byte, clamped to the legal range
  always_comb begin
    if (mem_rdata == '0) begin
      hdr_len = LEN_W'(1);
    end else if (mem_rdata > 8'(MAX_ELEM_BYTES)) begin
      hdr_len = LEN_W'(MAX_ELEM_BYTES);
    end else begin
      hdr_len = mem_rdata[LEN_W-1:0];
    end
    hdr_need = LEVEL_W'(HDR_BYTES) + LEVEL_W'(hdr_len);
  end

  // Clamp a written pool size to the supported range
  always_comb begin
    if (cfg_data > LEVEL_W'(POOL_DEPTH)) begin
      pool_cfg = LEVEL_W'(POOL_DEPTH);
    end else if (cfg_data < LEVEL_W'(POOL_MIN)) begin
      pool_cfg = LEVEL_W'(POOL_MIN);
    end else begin
      pool_cfg = cfg_data;
    end
  end

  assign cursor_adv = wrap_add(cursor, 4'd1, pool);

  // Sequence transactions through the ring RAM
  always_comb begin
    state_next       = state;
    pool_next        = pool;
    write_index_next = write_index;
    read_index_next  = read_index;
    cursor_next      = cursor;
    rd_idx_next      = rd_idx;
    level_next       = level;
    count_next       = count;
    remaining_next   = remaining;
    push_len_next    = push_len;
    verdict_next     = verdict;
    pend_byte_next   = pend_byte;
    pull_len_next    = pull_len;
    pull_left_next   = pull_left;

    res_valid_next   = 1'b0;
    res_status_next  = STAT_OK;
    res_data_next    = '0;
    res_last_next    = 1'b0;
    res_len_next     = '0;

    mem_we           = 1'b0;
    mem_waddr        = cursor;
    mem_wdata        = pend_byte;
    mem_raddr        = read_index;

    byte_go          = 1'b0;
    byte_store       = 1'b0;
    byte_data        = push_byte;
    step_rem         = remaining;
    step_verdict     = verdict;
    step_len         = push_len;

    case (state)
      S_IDLE: begin
        if (start) begin
          case (opcode)
            OP_PUSH: begin
              if (remaining == '0) begin
                // First byte: latch length and verdict, write the header if accepted
                push_len_next  = len_in;
                verdict_next   = first_verdict;
                remaining_next = len_in;
                if (first_verdict == STAT_OK) begin
                  mem_we         = 1'b1;
                  mem_waddr      = write_index;
                  mem_wdata      = 8'(len_in);
                  cursor_next    = wrap_add(write_index, 4'(HDR_BYTES), pool);
                  pend_byte_next = push_byte;
                  state_next     = S_PUSH;
                end else begin
                  byte_go      = 1'b1;
                  step_rem     = len_in;
                  step_verdict = first_verdict;
                  step_len     = len_in;
                end
              end else begin
                byte_go    = 1'b1;
                byte_store = (verdict == STAT_OK);
              end
            end
            OP_PULL: begin
              if ((count == '0) || (level == '0)) begin
                res_valid_next  = 1'b1;
                res_status_next = STAT_EMPTY;
                res_last_next   = 1'b1;
              end else begin
                mem_raddr   = read_index;
                rd_idx_next = wrap_add(read_index, 4'(HDR_BYTES), pool);
                state_next  = S_PULL_HDR;
              end
            end
            OP_CLEAR: begin
              write_index_next = '0;
              read_index_next  = '0;
              level_next       = '0;
              count_next       = '0;
              remaining_next   = '0;
              cursor_next      = '0;
              verdict_next     = STAT_OK;
              push_len_next    = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_PUSH: begin
        // Store the payload byte held back behind the header write
        byte_go    = 1'b1;
        byte_store = 1'b1;
        byte_data  = pend_byte;
      end
      S_PULL_HDR: begin
        // Drop the element from the level and start reading its payload
        if (hdr_need > level) begin
          level_next = '0;
        end else begin
          level_next = level - hdr_need;
        end
        count_next     = (level_next == '0) ? '0 : count - LEVEL_W'(1);
        pull_len_next  = hdr_len;
        pull_left_next = hdr_len;
        mem_raddr      = rd_idx;
        rd_idx_next    = wrap_add(rd_idx, 4'd1, pool);
        state_next     = S_PULL_DATA;
      end
      S_PULL_DATA: begin
        res_valid_next  = 1'b1;
        res_status_next = STAT_OK;
        res_data_next   = mem_rdata;
        res_len_next    = pull_len;
        res_last_next   = (pull_left == LEN_W'(1));
        pull_left_next  = pull_left - LEN_W'(1);
        if (pull_left != LEN_W'(1)) begin
          mem_raddr   = rd_idx;
          rd_idx_next = wrap_add(rd_idx, 4'd1, pool);
        end else begin
          read_index_next = rd_idx;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Take one push byte: store it if accepted, count down, commit on the final byte
    if (byte_go) begin
      if (byte_store) begin
        mem_we      = 1'b1;
        mem_waddr   = cursor;
        mem_wdata   = byte_data;
        cursor_next = cursor_adv;
      end
      remaining_next = step_rem - LEN_W'(1);
      if (step_rem == LEN_W'(1)) begin
        if (step_verdict == STAT_OK) begin
          level_next       = level + LEVEL_W'(HDR_BYTES) + LEVEL_W'(step_len);
          count_next       = count + LEVEL_W'(1);
          write_index_next = cursor_adv;
        end
        res_valid_next  = 1'b1;
        res_status_next = step_verdict;
        res_len_next    = step_len;
        res_last_next   = 1'b1;
        verdict_next    = STAT_OK;
      end
      state_next = S_IDLE;
    end

    // A pool write empties the queue and drops any partial element
    if (cfg_we) begin
      pool_next        = pool_cfg;
      write_index_next = '0;
      read_index_next  = '0;
      level_next       = '0;
      count_next       = '0;
      remaining_next   = '0;
      cursor_next      = '0;
      verdict_next     = STAT_OK;
      push_len_next    = '0;
    end
  end

  // Hold state and registered result outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pool         <= LEVEL_W'(POOL_DEPTH);
      write_index  <= '0;
      read_index   <= '0;
      cursor       <= '0;
      level        <= '0;
      count        <= '0;
      remaining    <= '0;
      push_len     <= '0;
      verdict      <= STAT_OK;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      pool         <= pool_next;
      write_index  <= write_index_next;
      read_index   <= read_index_next;
      cursor       <= cursor_next;
      level        <= level_next;
      count        <= count_next;
      remaining    <= remaining_next;
      push_len     <= push_len_next;
      verdict      <= verdict_next;
      result_valid <= res_valid_next;
    end
    rd_idx      <= rd_idx_next;
    pend_byte   <= pend_byte_next;
    pull_len    <= pull_len_next;
    pull_left   <= pull_left_next;
    status      <= res_status_next;
    data_byte   <= res_data_next;
    last        <= res_last_next;
    elem_length <= res_len_next;
    fill_level  <= level_next;
    elem_count  <= count_next;
  end

endmodule

/* design/vlpf_checker.sv */
// ----------------------------------------------------------------------------
// vlpf_checker
// Port-level checks on the packet FIFO's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vlpf_checker import vlpf_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         opcode,
  input logic               result_valid,
  input logic [1:0]         status,
  input logic [7:0]         data_byte,
  input logic               last,
  input logic [LEN_W-1:0]   elem_length
);

  logic res_ok;
  logic res_err;
  logic res_empty;
  logic clear_go;
  logic bare_res;
  logic len_legal;

  // Classify the current result and command
  assign res_ok    = result_valid && (status == STAT_OK);
  assign res_err   = result_valid && (status != STAT_OK);
  assign res_empty = result_valid && (status == STAT_EMPTY);
  assign clear_go  = start && !busy && (opcode == OP_CLEAR);
  assign bare_res  = last && (data_byte == '0) && (elem_length == '0);
  assign len_legal = (elem_length != '0) && (elem_length <= LEN_W'(MAX_ELEM_BYTES));

  // An empty pull reports a bare status with no element
  `VLPF_ASSERT(a_empty_bare, res_empty |-> bare_res, "empty status carries data")

  // Every rejection or empty status is a single, final result
  `VLPF_ASSERT(a_error_last, res_err |-> last, "error status without last")

  // A good result always names a legal element length
  `VLPF_ASSERT(a_ok_len, res_ok |-> len_legal, "bad element length")

  // A clear transaction produces no result
  `VLPF_ASSERT_NEXT(a_clear_quiet, clear_go, !result_valid, "result after clear")

  // Pulled payload bytes stream without gaps until the last one
  `VLPF_ASSERT_NEXT(a_pull_stream, res_ok && !last, result_valid, "gap in pulled element")

endmodule

bind variable_length_packet_fifo_top vlpf_checker u_vlpf_checker (.*);

/* tb/variable_length_packet_fifo_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// variable_length_packet_fifo_top_test
// Self-checking bench for the length-prefixed packet FIFO. A queue of
// commands feeds a clocked driver that works in random bursts. Each accepted
// transaction goes through a ring model of the FIFO, which keeps the
// results it expects in order. A clocked monitor compares every result
// strobe, field by field, against the oldest expected result. The pool
// size is rewritten between phases, only after the block has gone quiet.
// ----------------------------------------------------------------------------
module variable_length_packet_fifo_top_test;
  import vlpf_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [1:0]       opcode;
    logic [7:0]       push_byte;
    logic [LEN_W-1:0] elem_len;
  } fifo_cmd_t;

  typedef struct {
    logic [1:0]         status;
    logic [7:0]         data_byte;
    logic               last;
    logic [LEN_W-1:0]   elem_length;
    logic [LEVEL_W-1:0] fill_level;
    logic [LEVEL_W-1:0] elem_count;
  } fifo_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         opcode = OP_PUSH;
  logic [7:0]         push_byte = 8'h00;
  logic [LEN_W-1:0]   elem_len = '0;
  logic               cfg_we = 1'b0;
  logic [LEVEL_W-1:0] cfg_data = '0;
  logic               result_valid;
  logic [1:0]         status;
  logic [7:0]         data_byte;
  logic               last;
  logic [LEN_W-1:0]   elem_length;
  logic [LEVEL_W-1:0] fill_level;
  logic [LEVEL_W-1:0] elem_count;

  fifo_cmd_t    pending_cmds[$];
  fifo_result_t awaited_results[$];
  int           mismatch_count = 0;
  int           items_queued = 0;
  int           idle_cycles = 0;
  int           burst_left = 0;
  int           gap_left = 0;

  // Ring model state
  logic [7:0]  ring_bytes [POOL_DEPTH];
  int unsigned pool_setting = POOL_DEPTH;
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;
  int unsigned bytes_held = 0;
  int unsigned elems_held = 0;
  int unsigned bytes_to_go = 0;
  int unsigned put_ptr = 0;
  int unsigned cur_len = 0;
  logic [1:0]  cur_verdict = STAT_OK;

  variable_length_packet_fifo_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .push_byte    (push_byte),
    .elem_len     (elem_len),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .status       (status),
    .data_byte    (data_byte),
    .last         (last),
    .elem_length  (elem_length),
    .fill_level   (fill_level),
    .elem_count   (elem_count)
  );

  always #5 clk = ~clk;

  // Clamp the written pool size to the range the ring supports.
  function automatic int unsigned pool_in_use();
    if (pool_setting > POOL_DEPTH) return POOL_DEPTH;
    if (pool_setting < POOL_MIN) return POOL_MIN;
    return pool_setting;
  endfunction

  function automatic void empty_ring();
    wr_ptr      = 0;
    rd_ptr      = 0;
    bytes_held  = 0;
    elems_held  = 0;
    bytes_to_go = 0;
    put_ptr     = 0;
    cur_verdict = STAT_OK;
    cur_len     = 0;
  endfunction

  function automatic void ring_put(logic [7:0] b);
    ring_bytes[put_ptr] = b;
    put_ptr = (put_ptr + 1) % pool_in_use();
  endfunction

  function automatic void expect_result(logic [1:0] st, logic [7:0] d, logic lst,
                                        int unsigned len);
    fifo_result_t r;
    r.status      = st;
    r.data_byte   = d;
    r.last        = lst;
    r.elem_length = LEN_W'(len);
    r.fill_level  = LEVEL_W'(bytes_held);
    r.elem_count  = LEVEL_W'(elems_held);
    awaited_results.push_back(r);
  endfunction

  // Advance the ring model by one accepted transaction.
  function automatic void predict_fifo_results(fifo_cmd_t c);
    int unsigned pool;
    int unsigned idx;
    int unsigned len;
    pool = pool_in_use();
    case (c.opcode)
      OP_PUSH: begin
        // Latch and check the length on the first byte of an element
        if (bytes_to_go == 0) begin
          len = (c.elem_len == 0) ? 1 : c.elem_len;
          cur_len = len;
          if (len > MAX_ELEM_BYTES || HDR_BYTES + len > pool) begin
            cur_verdict = STAT_TOO_BIG;
          end else if (bytes_held + HDR_BYTES + len > pool) begin
            cur_verdict = STAT_FULL;
          end else begin
            cur_verdict = STAT_OK;
          end
          if (cur_verdict == STAT_OK) begin
            put_ptr = wr_ptr;
            for (int h = 0; h < HDR_BYTES; h++) begin
              ring_put((h < 4) ? 8'(len >> (8 * h)) : 8'h00);
            end
          end
          bytes_to_go = len;
        end
        if (cur_verdict == STAT_OK) ring_put(c.push_byte);
        bytes_to_go--;
        // Commit on the final byte and report the verdict
        if (bytes_to_go == 0) begin
          if (cur_verdict == STAT_OK) begin
            bytes_held += HDR_BYTES + cur_len;
            elems_held++;
            wr_ptr = put_ptr;
          end
          expect_result(cur_verdict, 8'h00, 1'b1, cur_len);
          cur_verdict = STAT_OK;
        end
      end
      OP_PULL: begin
        if (elems_held == 0 || bytes_held == 0) begin
          expect_result(STAT_EMPTY, 8'h00, 1'b1, 0);
        end else begin
          // Decode the little-endian header, then walk out the payload
          idx = rd_ptr;
          len = 0;
          for (int h = 0; h < HDR_BYTES; h++) begin
            if (h < 4) len |= 32'(ring_bytes[idx]) << (8 * h);
            idx = (idx + 1) % pool;
          end
          if (len > MAX_ELEM_BYTES) len = MAX_ELEM_BYTES;
          if (len == 0) len = 1;
          if (HDR_BYTES + len > bytes_held) bytes_held = 0;
          else bytes_held -= HDR_BYTES + len;
          elems_held--;
          if (bytes_held == 0) elems_held = 0;
          for (int k = 0; k < len; k++) begin
            expect_result(STAT_OK, ring_bytes[idx], (k + 1 == len), len);
            idx = (idx + 1) % pool;
          end
          rd_ptr = idx;
        end
      end
      OP_CLEAR: empty_ring();
      default: ;
    endcase
  endfunction

  // Drive commands in bursts; hold a transaction until it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_fifo_results(pending_cmds.pop_front());
      if (start && busy) begin
        // hold the current transaction
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 24);
        end
        start     <= 1'b1;
        opcode    <= pending_cmds[0].opcode;
        push_byte <= pending_cmds[0].push_byte;
        elem_len  <= pending_cmds[0].elem_len;
        burst_left--;
        if (burst_left == 0) gap_left = $urandom_range(1, 10);
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each result strobe against the oldest expected result.
  always @(posedge clk) begin
    fifo_result_t want;
    if (!rst && result_valid) begin
      if (awaited_results.size() == 0) begin
        $error("result with none expected: status %0d data_byte %0d", status, data_byte);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 16'(want.status), 16'(status));
        check_field("data_byte", 16'(want.data_byte), 16'(data_byte));
        check_field("last", 16'(want.last), 16'(last));
        check_field("elem_length", 16'(want.elem_length), 16'(elem_length));
        check_field("fill_level", 16'(want.fill_level), 16'(fill_level));
        check_field("elem_count", 16'(want.elem_count), 16'(elem_count));
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic queue_cmd(logic [1:0] op, logic [7:0] b, logic [LEN_W-1:0] len);
    fifo_cmd_t c;
    c.opcode    = op;
    c.push_byte = b;
    c.elem_len  = len;
    pending_cmds.push_back(c);
    if (op != OP_UNUSED) items_queued++;
  endtask

  // Queue a whole element, optionally with a pull in the middle of it.
  task automatic queue_element(logic [LEN_W-1:0] len, bit with_pull);
    int n;
    n = (len == 0) ? 1 : int'(len);
    for (int i = 0; i < n; i++) begin
      if (with_pull && i == n / 2) queue_cmd(OP_PULL, 8'($urandom), LEN_W'($urandom));
      queue_cmd(OP_PUSH, 8'($urandom_range(0, 255)), len);
    end
  endtask

  task automatic queue_random_phase(int target);
    int unsigned cap;
    int unsigned small_cap;
    int          first;
    int          r;
    int          len;
    cap = pool_in_use() - HDR_BYTES;
    if (cap > MAX_ELEM_BYTES) cap = MAX_ELEM_BYTES;
    small_cap = (cap < 12) ? cap : 12;
    first = items_queued;
    while (items_queued - first < target) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cap)
                                          : $urandom_range(1, small_cap);
        queue_element(LEN_W'(len), $urandom_range(0, 9) == 0);
      end else if (r < 53) begin
        queue_element(LEN_W'(0), 1'b0);
      end else if (r < 55) begin
        // oversized element: beyond the pool or beyond the element limit
        len = (cap < MAX_ELEM_BYTES) ? cap + $urandom_range(1, 3)
                                     : $urandom_range(MAX_ELEM_BYTES + 1, 127);
        queue_element(LEN_W'(len), 1'b0);
      end else if (r < 80) begin
        queue_cmd(OP_PULL, 8'($urandom), LEN_W'($urandom));
      end else if (r < 84) begin
        queue_cmd(OP_CLEAR, 8'($urandom), LEN_W'($urandom));
      end else if (r < 87) begin
        queue_cmd(OP_UNUSED, 8'($urandom), LEN_W'($urandom));
      end else begin
        // broken element: cut short, lengths changing mid-element
        len = $urandom_range(2, small_cap + 1);
        queue_cmd(OP_PUSH, 8'($urandom), LEN_W'(len));
        repeat ($urandom_range(0, len - 2)) begin
          queue_cmd(OP_PUSH, 8'($urandom), LEN_W'($urandom));
        end
        if ($urandom_range(0, 1) == 0) queue_cmd(OP_CLEAR, 8'($urandom), LEN_W'($urandom));
      end
    end
  endtask

  // Wait until the block has drained every outstanding transaction.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool(logic [LEVEL_W-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    pool_setting = 32'(value);
    empty_ring();
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [LEVEL_W-1:0] pools [9];
    pools = '{13'd0, 13'd40, 13'd8191, 13'd100, 13'd5000, 13'd16, 13'd4095,
              13'd300, 13'd4096};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_pool(13'd4096);

    // Directed: empty pull, length extremes, pull mid-push, unknown op, clear
    queue_cmd(OP_PULL, 8'hFF, 7'h7F);
    queue_cmd(OP_PUSH, 8'h00, 7'd1);
    queue_cmd(OP_PUSH, 8'hFF, 7'd0);
    queue_cmd(OP_PUSH, 8'h55, 7'd2);
    queue_cmd(OP_PULL, 8'h00, 7'd0);
    queue_cmd(OP_PUSH, 8'hAA, 7'h7F);
    queue_cmd(OP_UNUSED, 8'hFF, 7'h7F);
    repeat (4) queue_cmd(OP_PULL, 8'h00, 7'd0);
    queue_cmd(OP_PUSH, 8'h81, 7'd3);
    queue_cmd(OP_CLEAR, 8'h00, 7'd0);
    queue_cmd(OP_PULL, 8'h00, 7'd0);
    wait_idle();

    // Directed at the smallest pool: exact fill, full, then a dropped element
    write_pool(13'd16);
    queue_element(7'd8, 1'b0);
    queue_cmd(OP_PUSH, 8'h3C, 7'd1);
    queue_cmd(OP_PULL, 8'h00, 7'd0);
    queue_cmd(OP_PUSH, 8'hC3, 7'd5);
    wait_idle();

    foreach (pools[i]) begin
      write_pool(pools[i]);
      queue_random_phase(30);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/vlpf_pkg.sv
design/vlpf_ring_ram.sv
design/variable_length_packet_fifo_top.sv
design/vlpf_checker.sv
tb/variable_length_packet_fifo_top_test.sv
